// ===== rtl/core/cau_pkg.sv =====
package cau_pkg;

  // Operand and fixed-point geometry (signed Q16.16)
  localparam int DW  = 32;
  localparam int FB  = 16;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  // Opcodes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [1:0]           opcode;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic [1:0]           status;
  } cau_out_t;

  // Classified item passed from front to back
  typedef struct packed {
    cau_in_t op;
    logic    div_zero;
  } cau_item_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       div_zero;
  } cau_ctl_t;

  // One part of the result as it travels through the divider steps
  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
    logic          ovf;
    logic [PW-1:0] rem;
    logic [DW-1:0] nbits;
    logic [DW-1:0] quo;
  } cau_lane_t;

  typedef struct packed {
    cau_ctl_t      ctl;
    logic [PW-1:0] den;
    cau_lane_t     re;
    cau_lane_t     im;
  } cau_dstage_t;

endpackage

// ===== rtl/core/cau_queue.sv =====
module cau_queue
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  cau_item_t wr_item,
  input  logic      rd,
  output logic      q_full,
  output logic      q_valid,
  output cau_item_t q_item
);

  cau_item_t        mem_r [QD];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == QCW'(QD));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/core/cau_front.sv =====
module cau_front
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  cau_in_t   in_data,
  input  logic      q_full,
  output logic      f_move,
  output cau_item_t f_item
);

  logic      f_v_r, f_v_nxt;
  cau_item_t f_item_r;
  logic      accept;

  assign full   = f_v_r && q_full;
  assign accept = push && !full;
  assign f_move = f_v_r && !q_full;
  assign f_item = f_item_r;

  // Hold the beat until the queue takes it
  always_comb begin
    f_v_nxt = f_v_r;
    if (accept) begin
      f_v_nxt = 1'b1;
    end else if (f_move) begin
      f_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  // Capture and flag a zero divisor
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r.op       <= in_data;
      f_item_r.div_zero <= (in_data.opcode == OP_DIV) && (in_data.b_re == '0) &&
                           (in_data.b_im == '0);
    end
  end

endmodule

// ===== rtl/core/cau_back.sv =====
module cau_back
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cau_item_t q_item,
  output logic      q_take,
  output logic      res_empty,
  input  logic      pop,
  output cau_out_t  out_data
);

  localparam logic [PW-1:0] LIM = PW'(1) << (DW - 1);

  logic en;

  // Stage 1: products and sums
  logic                 v1_r;
  cau_ctl_t             ctl1_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, q_rr_r, q_ii_r;
  logic signed [DW:0]   as_re_r, as_im_r;
  logic signed [DW-1:0] ar, ai, br, bi;

  // Stage 2: combined values
  logic                 v2_r;
  cau_ctl_t             ctl2_r;
  logic signed [SW-1:0] s_re_r, s_im_r, s_re_nxt, s_im_nxt;
  logic [PW-1:0]        den2_r;

  // Stage 3: sign and magnitude
  logic                 v3_r;
  cau_ctl_t             ctl3_r;
  logic [PW-1:0]        den3_r;
  logic                 neg_re_r, neg_im_r;
  logic [PW-1:0]        mag_re_r, mag_im_r, mag_re_nxt, mag_im_nxt;
  logic [SW-1:0]        abs_re, abs_im;

  // Divider steps
  logic                 dv_r [DW+1];
  cau_dstage_t          ds_r [DW+1];
  cau_dstage_t          ds0_nxt;

  // Output register
  logic                 out_v_r;
  cau_out_t             out_r, out_nxt;

  function automatic cau_lane_t lane_init(logic neg, logic [PW-1:0] mag, logic [PW-1:0] den);
    cau_lane_t l;
    l.neg   = neg;
    l.mag   = mag;
    l.ovf   = ({{(DW-FB){1'b0}}, mag} >= {den, {(DW-FB){1'b0}}});
    l.rem   = mag >> (DW - FB);
    l.nbits = {mag[DW-FB-1:0], {FB{1'b0}}};
    l.quo   = '0;
    return l;
  endfunction

  function automatic cau_lane_t div_step(cau_lane_t l, logic [PW-1:0] den);
    cau_lane_t r;
    logic [PW:0] sh;
    logic [PW:0] df;
    r  = l;
    sh = {l.rem, l.nbits[DW-1]};
    df = sh - {1'b0, den};
    if (sh >= {1'b0, den}) begin
      r.rem = df[PW-1:0];
      r.quo = {l.quo[DW-2:0], 1'b1};
    end else begin
      r.rem = sh[PW-1:0];
      r.quo = {l.quo[DW-2:0], 1'b0};
    end
    r.nbits = {l.nbits[DW-2:0], 1'b0};
    return r;
  endfunction

  // Clamp a sign-magnitude value to the word range; top bit flags saturation
  function automatic logic [DW:0] clamp(logic neg, logic [PW-1:0] mag, logic big);
    logic [DW:0]   r;
    logic [PW-1:0] ng;
    ng = -mag;
    if (!neg) begin
      if (big || mag > LIM - 1'b1) begin
        r = {1'b1, 1'b0, {(DW-1){1'b1}}};
      end else begin
        r = {1'b0, mag[DW-1:0]};
      end
    end else begin
      if (big || mag > LIM) begin
        r = {1'b1, 1'b1, {(DW-1){1'b0}}};
      end else begin
        r = {1'b0, ng[DW-1:0]};
      end
    end
    return r;
  endfunction

  // Advance the whole pipe whenever the output slot frees
  assign en        = !out_v_r || pop;
  assign q_take    = en && q_valid;
  assign res_empty = !out_v_r;
  assign out_data  = out_r;

  assign ar = q_item.op.a_re;
  assign ai = q_item.op.a_im;
  assign br = q_item.op.b_re;
  assign bi = q_item.op.b_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k <= DW; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r     <= q_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      dv_r[0]  <= v3_r;
      for (int k = 0; k < DW; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      out_v_r  <= dv_r[DW];
    end
  end

  // Stage 1: multiply and add/sub
  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r.opcode   <= q_item.op.opcode;
      ctl1_r.div_zero <= q_item.div_zero;
      p_rr_r  <= ar * br;
      p_ii_r  <= ai * bi;
      p_ri_r  <= ar * bi;
      p_ir_r  <= ai * br;
      q_rr_r  <= br * br;
      q_ii_r  <= bi * bi;
      if (q_item.op.opcode == OP_SUB) begin
        as_re_r <= {ar[DW-1], ar} - {br[DW-1], br};
        as_im_r <= {ai[DW-1], ai} - {bi[DW-1], bi};
      end else begin
        as_re_r <= {ar[DW-1], ar} + {br[DW-1], br};
        as_im_r <= {ai[DW-1], ai} + {bi[DW-1], bi};
      end
    end
  end

  // Stage 2: combine products per opcode
  always_comb begin
    case (ctl1_r.opcode)
      OP_ADD, OP_SUB: begin
        s_re_nxt = SW'(as_re_r);
        s_im_nxt = SW'(as_im_r);
      end
      OP_MUL: begin
        s_re_nxt = SW'(p_rr_r) - SW'(p_ii_r);
        s_im_nxt = SW'(p_ri_r) + SW'(p_ir_r);
      end
      OP_DIV: begin
        s_re_nxt = SW'(p_rr_r) + SW'(p_ii_r);
        s_im_nxt = SW'(p_ir_r) - SW'(p_ri_r);
      end
      default: begin
        s_re_nxt = '0;
        s_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2_r <= ctl1_r;
      s_re_r <= s_re_nxt;
      s_im_r <= s_im_nxt;
      den2_r <= q_rr_r + q_ii_r;
    end
  end

  // Stage 3: take magnitude, truncate product toward zero
  always_comb begin
    abs_re     = s_re_r[SW-1] ? -s_re_r : s_re_r;
    abs_im     = s_im_r[SW-1] ? -s_im_r : s_im_r;
    mag_re_nxt = abs_re[PW-1:0];
    mag_im_nxt = abs_im[PW-1:0];
    if (ctl2_r.opcode == OP_MUL) begin
      mag_re_nxt = abs_re[PW-1:0] >> FB;
      mag_im_nxt = abs_im[PW-1:0] >> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl3_r   <= ctl2_r;
      den3_r   <= den2_r;
      neg_re_r <= s_re_r[SW-1];
      neg_im_r <= s_im_r[SW-1];
      mag_re_r <= mag_re_nxt;
      mag_im_r <= mag_im_nxt;
    end
  end

  // Stage 4: seed the divider and check quotient overflow
  always_comb begin
    ds0_nxt.ctl = ctl3_r;
    ds0_nxt.den = den3_r;
    ds0_nxt.re  = lane_init(neg_re_r, mag_re_r, den3_r);
    ds0_nxt.im  = lane_init(neg_im_r, mag_im_r, den3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0] <= ds0_nxt;
    end
  end

  // One quotient bit per step
  for (genvar g = 0; g < DW; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[g+1].ctl <= ds_r[g].ctl;
        ds_r[g+1].den <= ds_r[g].den;
        ds_r[g+1].re  <= div_step(ds_r[g].re, ds_r[g].den);
        ds_r[g+1].im  <= div_step(ds_r[g].im, ds_r[g].den);
      end
    end
  end

  // Final: pick quotient or value, saturate, set status
  always_comb begin
    logic          is_div;
    logic [DW:0]   c_re, c_im;
    logic [PW-1:0] m_re, m_im;
    is_div = (ds_r[DW].ctl.opcode == OP_DIV);
    m_re   = is_div ? PW'(ds_r[DW].re.quo) : ds_r[DW].re.mag;
    m_im   = is_div ? PW'(ds_r[DW].im.quo) : ds_r[DW].im.mag;
    c_re   = clamp(ds_r[DW].re.neg, m_re, is_div && ds_r[DW].re.ovf);
    c_im   = clamp(ds_r[DW].im.neg, m_im, is_div && ds_r[DW].im.ovf);
    out_nxt.res_re = c_re[DW-1:0];
    out_nxt.res_im = c_im[DW-1:0];
    out_nxt.status = (c_re[DW] || c_im[DW]) ? ST_SAT : ST_OK;
    if (is_div && ds_r[DW].ctl.div_zero) begin
      out_nxt.res_re = '0;
      out_nxt.res_im = '0;
      out_nxt.status = ST_DIV0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// Throughput: one beat per cycle unless a held result stalls the pipe; the
// 32-step restoring divider is fully pipelined, one quotient bit per stage,
// so no opcode blocks the next.
// Reset: synchronous, active low; clears all valid flags and queue pointers.
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  cau_in_t  in_data,
  output logic     empty,
  input  logic     pop,
  output cau_out_t out_data
);

  logic      q_full;
  logic      q_valid;
  logic      q_take;
  logic      f_move;
  cau_item_t f_item;
  cau_item_t q_item;

  cau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_full  (q_full),
    .f_move  (f_move),
    .f_item  (f_item)
  );

  cau_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (f_move),
    .wr_item (f_item),
    .rd      (q_take),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  cau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .res_empty (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/cau_checker.sv =====
module cau_checker
  import cau_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     empty,
  input logic     pop,
  input cau_out_t out_data
);

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  // Reset drains the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // Divide by zero gives zero parts
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_DIV0) |-> (out_data.res_re == '0 && out_data.res_im == '0))
    else $error("divide-by-zero beat with nonzero parts");

  // Saturation leaves at least one part at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_SAT) |->
      (out_data.res_re == MAXV || out_data.res_re == MINV ||
       out_data.res_im == MAXV || out_data.res_im == MINV))
    else $error("saturated beat with no part at a limit");

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result beat dropped or changed while stalled");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

// ===== test/tb.sv =====
module tb;
  import cau_pkg::*;

  localparam int LATENCY  = 38;
  localparam int WDOG_MAX = 20000;
  localparam int N_RAND   = 1930;
  localparam logic signed [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};

  logic     clk;
  logic     rst_n;
  logic     push;
  logic     full;
  cau_in_t  in_data;
  logic     empty;
  logic     pop;
  cau_out_t out_data;

  cau_in_t  op_queue[$];
  cau_out_t result_queue[$];
  int       n_fail;
  int       n_done;
  int       n_sat;
  int       n_div0;
  int       quiet_cycles;
  bit       stim_done;
  bit       calm;
  int       hold_count;
  bit       hold_done;

  complex_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp an exact part into Q16.16 and note saturation
  function automatic logic signed [DW-1:0] clamp(input logic signed [160:0] v,
                                                  inout bit sat);
    if (v > 161'(signed'(QMAX))) begin
      sat = 1'b1;
      return QMAX;
    end
    if (v < 161'(signed'(QMIN))) begin
      sat = 1'b1;
      return QMIN;
    end
    return v[DW-1:0];
  endfunction

  // Truncating signed division of num * 2^FB by a positive den
  function automatic logic signed [160:0] quot(input logic signed [160:0] num,
                                               input logic signed [160:0] den);
    logic signed [160:0] mag;
    logic signed [160:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FB) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cau_out_t complex_result(input cau_in_t x);
    cau_out_t r;
    logic signed [160:0] ar, ai, br, bi, re, im, den;
    bit sat;
    ar = x.a_re;
    ai = x.a_im;
    br = x.b_re;
    bi = x.b_im;
    sat = 1'b0;
    case (x.opcode)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = quot(ar * br - ai * bi, 161'sd1 <<< (2 * FB));
        im = quot(ar * bi + ai * br, 161'sd1 <<< (2 * FB));
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.res_re = '0;
          r.res_im = '0;
          r.status = ST_DIV0;
          return r;
        end
        re = quot(ar * br + ai * bi, den);
        im = quot(ai * br - ar * bi, den);
      end
    endcase
    r.res_re = clamp(re, sat);
    r.res_im = clamp(im, sat);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return QMAX;
      1: return QMIN;
      2: return '0;
      3: return DW'($urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000);
      4, 5: return DW'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic add_op(input logic [1:0] opc, input logic [DW-1:0] a, input logic [DW-1:0] b,
                        input logic [DW-1:0] c, input logic [DW-1:0] d);
    cau_in_t x;
    x.opcode = opc;
    x.a_re = a;
    x.a_im = b;
    x.b_re = c;
    x.b_im = d;
    op_queue.push_back(x);
  endtask

  // Build the stimulus: directed corners first, then random operations
  initial begin
    cau_in_t x;
    for (int k = 0; k < 4; k++) begin
      add_op(k[1:0], 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
      add_op(k[1:0], QMAX, QMAX, QMAX, QMAX);
      add_op(k[1:0], QMIN, QMIN, QMAX, QMIN);
      add_op(k[1:0], QMIN, QMAX, '0, '0);
    end
    add_op(OP_DIV, '0, '0, '0, '0);
    add_op(OP_DIV, 32'h0001_0000, 32'h0000_0001, 32'h0000_0001, '0);
    add_op(OP_DIV, QMIN, QMIN, QMIN, QMIN);
    add_op(OP_MUL, QMIN, '0, QMIN, '0);
    add_op(OP_SUB, '0, QMIN, QMAX, QMAX);
    add_op(OP_ADD, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_0000, 32'h0000_FFFF);
    for (int k = 0; k < N_RAND; k++) begin
      x.opcode = 2'($urandom_range(0, 3));
      x.a_re = rand_part();
      x.a_im = rand_part();
      x.b_re = rand_part();
      x.b_im = rand_part();
      op_queue.push_back(x);
    end
  end

  // Reset sequencing
  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: offer the next operation, idling now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_data <= '0;
      stim_done <= 1'b0;
    end else begin
      if (push && !full) void'(op_queue.pop_front());
      if ((push && full) || (op_queue.size() > (push && !full ? 0 : 0) &&
          (calm || $urandom_range(0, 99) >= 7))) begin
        if (push && full) begin
          push <= 1'b1;
        end else if (op_queue.size() > 0) begin
          push <= 1'b1;
          in_data <= op_queue[0];
        end else begin
          push <= 1'b0;
          stim_done <= 1'b1;
        end
      end else begin
        push <= 1'b0;
        if (op_queue.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && push && !full) result_queue.push_back(complex_result(in_data));
  end

  // Receiver: pop at random, with one long hold-off to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      hold_count <= 0;
      hold_done <= 1'b0;
    end else if (hold_count > 0) begin
      pop <= 1'b0;
      hold_count <= hold_count - 1;
    end else if (!hold_done && n_done >= 300) begin
      pop <= 1'b0;
      hold_count <= 200;
      hold_done <= 1'b1;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // Quiet stretch with no idling on either side
  always @(posedge clk) calm <= (n_done >= 800 && n_done < 1100);

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    cau_out_t exp_r;
    int       errs;
    if (!rst_n) begin
      n_fail <= 0;
      n_done <= 0;
      n_sat <= 0;
      n_div0 <= 0;
    end else if (pop && !empty) begin
      n_done <= n_done + 1;
      errs = 0;
      if (result_queue.size() == 0) begin
        $error("unexpected result beat re=%h im=%h", out_data.res_re, out_data.res_im);
        errs = 1;
      end else begin
        exp_r = result_queue.pop_front();
        if (exp_r.status == ST_SAT) n_sat <= n_sat + 1;
        if (exp_r.status == ST_DIV0) n_div0 <= n_div0 + 1;
        if (out_data.res_re !== exp_r.res_re) begin
          $error("res_re expected %h got %h", exp_r.res_re, out_data.res_re);
          errs = errs + 1;
        end
        if (out_data.res_im !== exp_r.res_im) begin
          $error("res_im expected %h got %h", exp_r.res_im, out_data.res_im);
          errs = errs + 1;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, out_data.status);
          errs = errs + 1;
        end
      end
      n_fail <= n_fail + errs;
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // End of run
  initial begin
    @(posedge rst_n);
    while (!(stim_done && result_queue.size() == 0) && quiet_cycles < WDOG_MAX)
      @(posedge clk);
    if (quiet_cycles >= WDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
      $display("Checked %0d results (%0d saturated, %0d divide by zero) over all opcodes",
               n_done, n_sat, n_div0);
      if (n_fail == 0 && !empty == 1'b0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/core/cau_pkg.sv
rtl/core/cau_queue.sv
rtl/core/cau_front.sv
rtl/core/cau_back.sv
rtl/core/complex_arithmetic_unit.sv
rtl/core/cau_checker.sv
test/tb.sv
